@@ rtl/core/tlik_pkg.sv @@
// Shared constants, widths, arctangent table and pipeline side records
// for the two-link leg IK servo block. No dependencies.
package tlik_pkg;

  // PWM compare resolution and CORDIC depth (CORDIC_STEPS at most 24)
  localparam int DUTY_BITS    = 16;
  localparam int CORDIC_STEPS = 16;

  // Square-root pipeline: one result bit per stage
  localparam int DISC_W    = 52;
  localparam int ROOT_W    = DISC_W / 2;
  localparam int ISQ_STEPS = ROOT_W;

  // Datapath widths
  localparam int N_W   = 27;            // cosine numerators, signed
  localparam int CIN_W = 28;            // CORDIC operands, signed
  localparam int CX_W  = CIN_W + 18;    // CORDIC x/y, Q16 plus gain headroom
  localparam int Z_W   = 26;            // angles, Q16 degrees, signed

  localparam int Q16_ONE = 65536;
  localparam logic signed [Z_W-1:0] Z_90  = Z_W'(90 * Q16_ONE);
  localparam logic signed [Z_W-1:0] Z_N90 = Z_W'(-90 * Q16_ONE);

  // Reciprocal of 180 for the pulse scaling
  localparam int      RECIP_SHIFT = 30;
  localparam longint  RECIP_180   = (64'sd1 <<< RECIP_SHIFT) / 180;

  localparam int FRONT_LAT = 4;
  localparam int COR_LAT   = CORDIC_STEPS + 1;
  localparam int SERVO_LAT = 5 + DUTY_BITS;

  // atan(2^-i) in Q16 degrees, rounded to nearest
  function automatic logic signed [Z_W-1:0] atan_q16(input int i);
    logic signed [Z_W-1:0] v;
    case (i)
      0:  v = Z_W'(2949120);
      1:  v = Z_W'(1740967);
      2:  v = Z_W'(919879);
      3:  v = Z_W'(466945);
      4:  v = Z_W'(234379);
      5:  v = Z_W'(117304);
      6:  v = Z_W'(58666);
      7:  v = Z_W'(29335);
      8:  v = Z_W'(14668);
      9:  v = Z_W'(7334);
      10: v = Z_W'(3667);
      11: v = Z_W'(1833);
      12: v = Z_W'(917);
      13: v = Z_W'(458);
      14: v = Z_W'(229);
      15: v = Z_W'(115);
      16: v = Z_W'(57);
      17: v = Z_W'(29);
      18: v = Z_W'(14);
      19: v = Z_W'(7);
      20: v = Z_W'(4);
      21: v = Z_W'(2);
      22: v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Side record leaving the front end, carried along the square roots
  typedef struct packed {
    logic                  vld;
    logic [1:0]            leg;
    logic [7:0]            yaw;
    logic [7:0]            x;
    logic signed [8:0]     y;
    logic                  ok;
    logic signed [N_W-1:0] n1;
    logic signed [N_W-1:0] n2;
  } front_t;

  // Side record carried along the CORDIC units
  typedef struct packed {
    logic       vld;
    logic [1:0] leg;
    logic [7:0] yaw;
    logic       ok;
    logic       x_zero;
    logic       y_pos;
  } mid_t;

  // Servo angles carried along the duty units
  typedef struct packed {
    logic       vld;
    logic [1:0] leg;
    logic       ok;
    logic [7:0] fem;
    logic [7:0] tib;
    logic [7:0] yaw;
  } ang_t;

endpackage

@@ rtl/core/tlik_front.sv @@
// Front end: squares, cosine numerators and discriminants, four stages.
// Depends on tlik_pkg.
module tlik_front import tlik_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              vld_i,
  input  logic [7:0]        x_i,
  input  logic signed [8:0] y_i,
  input  logic [7:0]        yaw_i,
  input  logic [1:0]        leg_i,
  input  logic [11:0]       l1_i,
  input  logic [11:0]       l2_i,
  output front_t            side_o,
  output logic [DISC_W-1:0] disc1_o,
  output logic [DISC_W-1:0] disc2_o
);

  front_t a_side_r, a_side_nxt, b_side_r, b_side_nxt, c_side_r, d_side_r, d_side_nxt;

  logic [15:0] a_xsq_r;
  logic [16:0] a_ysq_r;
  logic [23:0] a_l1sq_r, a_l2sq_r;
  logic [8:0]  ay;
  logic [17:0] ysq_full;

  logic [24:0] b_s_r, b_s_nxt;
  logic [23:0] b_l1sq_r, b_l2sq_r;
  logic [16:0] sq_sum;

  logic [48:0] c_p1_r;
  logic [47:0] c_p2_r;
  logic [DISC_W-1:0] c_q1_r, c_q2_r;
  logic signed [53:0] q1_full, q2_full;

  logic signed [53:0] d1, d2;
  logic [DISC_W-1:0]  d_disc1_r, d_disc2_r;

  // Stage A: squares
  always_comb begin
    ay         = y_i[8] ? 9'(-y_i) : y_i;
    ysq_full   = ay * ay;
    a_side_nxt = '0;
    a_side_nxt.vld = vld_i;
    a_side_nxt.leg = leg_i;
    a_side_nxt.yaw = yaw_i;
    a_side_nxt.x   = x_i;
    a_side_nxt.y   = y_i;
    a_side_nxt.ok  = (l1_i != '0) && (l2_i != '0);
  end

  // Stage B: reach squared and numerators
  always_comb begin
    sq_sum     = {1'b0, a_xsq_r} + a_ysq_r;
    b_s_nxt    = {sq_sum, 8'h00};
    b_side_nxt = a_side_r;
    b_side_nxt.ok = a_side_r.ok && (sq_sum != '0);
    b_side_nxt.n1 = $signed({3'b000, a_l1sq_r}) + $signed({2'b00, b_s_nxt})
                    - $signed({3'b000, a_l2sq_r});
    b_side_nxt.n2 = $signed({3'b000, a_l1sq_r}) + $signed({3'b000, a_l2sq_r})
                    - $signed({2'b00, b_s_nxt});
  end

  // Stage C: products
  always_comb begin
    q1_full = b_side_r.n1 * b_side_r.n1;
    q2_full = b_side_r.n2 * b_side_r.n2;
  end

  // Stage D: discriminants and their sign
  always_comb begin
    d1 = $signed({3'b000, c_p1_r, 2'b00}) - $signed({2'b00, c_q1_r});
    d2 = $signed({4'b0000, c_p2_r, 2'b00}) - $signed({2'b00, c_q2_r});
    d_side_nxt    = c_side_r;
    d_side_nxt.ok = c_side_r.ok && !d1[53] && !d2[53];
  end

  always_ff @(posedge clk) begin
    a_xsq_r  <= x_i * x_i;
    a_ysq_r  <= ysq_full[16:0];
    a_l1sq_r <= l1_i * l1_i;
    a_l2sq_r <= l2_i * l2_i;
    b_s_r    <= b_s_nxt;
    b_l1sq_r <= a_l1sq_r;
    b_l2sq_r <= a_l2sq_r;
    c_p1_r   <= b_l1sq_r * b_s_r;
    c_p2_r   <= b_l1sq_r * b_l2sq_r;
    c_q1_r   <= q1_full[DISC_W-1:0];
    c_q2_r   <= q2_full[DISC_W-1:0];
    d_disc1_r <= d1[DISC_W-1:0];
    d_disc2_r <= d2[DISC_W-1:0];
    if (!rst_n) begin
      a_side_r.vld <= 1'b0;
      b_side_r.vld <= 1'b0;
      c_side_r.vld <= 1'b0;
      d_side_r.vld <= 1'b0;
    end else begin
      a_side_r <= a_side_nxt;
      b_side_r <= b_side_nxt;
      c_side_r <= b_side_r;
      d_side_r <= d_side_nxt;
    end
  end

  assign side_o  = d_side_r;
  assign disc1_o = d_disc1_r;
  assign disc2_o = d_disc2_r;

endmodule

@@ rtl/core/tlik_isqrt.sv @@
// Pipelined floor square root, one root bit per stage.
// Depends on tlik_pkg.
module tlik_isqrt import tlik_pkg::*; (
  input  logic              clk,
  input  logic [DISC_W-1:0] v_i,
  output logic [ROOT_W-1:0] root_o
);

  localparam int RW = ROOT_W + 2;

  logic [RW-1:0]     rem_r   [ISQ_STEPS];
  logic [RW-1:0]     rem_nxt [ISQ_STEPS];
  logic [ROOT_W-1:0] root_r  [ISQ_STEPS];
  logic [ROOT_W-1:0] root_nxt[ISQ_STEPS];
  logic [DISC_W-1:0] rad_r   [ISQ_STEPS];
  logic [DISC_W-1:0] rad_nxt [ISQ_STEPS];

  always_comb begin
    logic [RW-1:0]     src_rem;
    logic [ROOT_W-1:0] src_root;
    logic [DISC_W-1:0] src_rad;
    logic [RW+1:0]     rr;
    logic [RW-1:0]     trial;
    for (int k = 0; k < ISQ_STEPS; k++) begin
      if (k == 0) begin
        src_rem  = '0;
        src_root = '0;
        src_rad  = v_i;
      end else begin
        src_rem  = rem_r[k-1];
        src_root = root_r[k-1];
        src_rad  = rad_r[k-1];
      end
      rr    = {src_rem, src_rad[DISC_W-1 -: 2]};
      trial = {src_root, 2'b01};
      if (rr >= {2'b00, trial}) begin
        rem_nxt[k]  = RW'(rr - {2'b00, trial});
        root_nxt[k] = {src_root[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = rr[RW-1:0];
        root_nxt[k] = {src_root[ROOT_W-2:0], 1'b0};
      end
      rad_nxt[k] = src_rad << 2;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < ISQ_STEPS; k++) begin
      rem_r[k]  <= rem_nxt[k];
      root_r[k] <= root_nxt[k];
      rad_r[k]  <= rad_nxt[k];
    end
  end

  assign root_o = root_r[ISQ_STEPS-1];

endmodule

@@ rtl/core/tlik_cordic.sv @@
// Pipelined vectoring CORDIC: atan2(b, a) in Q16 degrees.
// Depends on tlik_pkg (widths, arctangent table).
module tlik_cordic import tlik_pkg::*; (
  input  logic                    clk,
  input  logic signed [CIN_W-1:0] a_i,
  input  logic signed [CIN_W-1:0] b_i,
  output logic signed [Z_W-1:0]   z_o
);

  logic signed [CX_W-1:0] x_r  [CORDIC_STEPS+1];
  logic signed [CX_W-1:0] y_r  [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  z_r  [CORDIC_STEPS+1];
  logic signed [CX_W-1:0] x_nxt[CORDIC_STEPS+1];
  logic signed [CX_W-1:0] y_nxt[CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  z_nxt[CORDIC_STEPS+1];

  always_comb begin
    logic signed [CX_W-1:0] ax, bx, dx, dy;
    ax = {{(CX_W-CIN_W-16){a_i[CIN_W-1]}}, a_i, 16'h0000};
    bx = {{(CX_W-CIN_W-16){b_i[CIN_W-1]}}, b_i, 16'h0000};
    // pre-rotate a left-half vector by -90 degrees
    if (ax < 0) begin
      x_nxt[0] = bx;
      y_nxt[0] = -ax;
      z_nxt[0] = Z_90;
    end else begin
      x_nxt[0] = ax;
      y_nxt[0] = bx;
      z_nxt[0] = '0;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y_r[i] >>> i;
      dy = x_r[i] >>> i;
      if (y_r[i] >= 0) begin
        x_nxt[i+1] = x_r[i] + dx;
        y_nxt[i+1] = y_r[i] - dy;
        z_nxt[i+1] = z_r[i] + atan_q16(i);
      end else begin
        x_nxt[i+1] = x_r[i] - dx;
        y_nxt[i+1] = y_r[i] + dy;
        z_nxt[i+1] = z_r[i] - atan_q16(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i <= CORDIC_STEPS; i++) begin
      x_r[i] <= x_nxt[i];
      y_r[i] <= y_nxt[i];
      z_r[i] <= z_nxt[i];
    end
  end

  assign z_o = z_r[CORDIC_STEPS];

endmodule

@@ rtl/core/tlik_servo.sv @@
// Servo angle to PWM compare: pulse scaling by reciprocal of 180, then a
// pipelined restoring divide by the frame. Depends on tlik_pkg.
module tlik_servo import tlik_pkg::*; (
  input  logic        clk,
  input  logic [7:0]  angle_i,
  input  logic [14:0] pmin_i,
  input  logic [14:0] pmax_i,
  input  logic [15:0] frame_i,
  output logic [15:0] duty_o
);

  localparam int NW = DUTY_BITS + 19;
  localparam int DW = (DUTY_BITS > 16) ? DUTY_BITS : 16;
  localparam logic [DUTY_BITS-1:0] MAXD = '1;

  // stage 1
  logic signed [24:0] s1_p_r;
  logic signed [15:0] span;
  logic signed [24:0] p_full;
  // stage 2
  logic        s2_neg_r;
  logic [23:0] s2_m_r;
  logic [46:0] s2_prod_r;
  logic [23:0] mag;
  // stage 3
  logic        s3_neg_r;
  logic [23:0] s3_m_r;
  logic [16:0] s3_q0_r;
  logic [24:0] s3_qm_r;
  // stage 4
  logic signed [17:0] s4_pulse_r;
  logic [23:0]        rmd;
  logic [16:0]        qc;
  logic signed [17:0] sq;
  // stage 5 and divider
  logic [16:0]          pc;
  logic [15:0]          fr;
  logic [DUTY_BITS+16:0] pm;
  logic [NW-1:0]        num;
  logic [NW-1:0]        rem_r  [DUTY_BITS+1];
  logic [NW-1:0]        rem_nxt[DUTY_BITS+1];
  logic [DUTY_BITS-1:0] q_r    [DUTY_BITS+1];
  logic [DUTY_BITS-1:0] q_nxt  [DUTY_BITS+1];
  logic [16:0]          dv_r   [DUTY_BITS+1];
  logic                 ovf_r  [DUTY_BITS+1];
  logic                 ovf0;
  logic [DUTY_BITS-1:0] full;
  logic [DW-1:0]        dext;

  always_comb begin
    span   = $signed({1'b0, pmax_i}) - $signed({1'b0, pmin_i});
    p_full = $signed({1'b0, angle_i}) * span;
    mag    = s1_p_r[24] ? 24'(-s1_p_r) : s1_p_r[23:0];
    rmd    = s3_m_r - s3_qm_r[23:0];
    qc     = s3_q0_r + 17'(rmd >= 24'd180);
    sq     = s3_neg_r ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
  end

  always_comb begin
    logic [NW-1:0] trial;
    pc   = (s4_pulse_r > 0) ? s4_pulse_r[16:0] : '0;
    fr   = (frame_i == '0) ? 16'd1 : frame_i;
    pm   = {pc, {DUTY_BITS{1'b0}}} - (DUTY_BITS+17)'(pc);
    num  = NW'({pm, 1'b0}) + NW'(fr);
    ovf0 = num >= (NW'({fr, 1'b0}) << DUTY_BITS);
    rem_nxt[0] = num;
    q_nxt[0]   = '0;
    for (int j = 0; j < DUTY_BITS; j++) begin
      trial        = NW'(dv_r[j]) << (DUTY_BITS - 1 - j);
      q_nxt[j+1]   = q_r[j];
      rem_nxt[j+1] = rem_r[j];
      if (rem_r[j] >= trial) begin
        rem_nxt[j+1] = rem_r[j] - trial;
        q_nxt[j+1][DUTY_BITS-1-j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_p_r     <= p_full;
    s2_neg_r   <= s1_p_r[24];
    s2_m_r     <= mag;
    s2_prod_r  <= mag * 23'(RECIP_180);
    s3_neg_r   <= s2_neg_r;
    s3_m_r     <= s2_m_r;
    s3_q0_r    <= s2_prod_r[46:RECIP_SHIFT];
    s3_qm_r    <= s2_prod_r[46:RECIP_SHIFT] * 8'd180;
    s4_pulse_r <= $signed({3'b000, pmin_i}) + sq;
    dv_r[0]    <= {fr, 1'b0};
    ovf_r[0]   <= ovf0;
    for (int j = 0; j <= DUTY_BITS; j++) begin
      rem_r[j] <= rem_nxt[j];
      q_r[j]   <= q_nxt[j];
    end
    for (int j = 1; j <= DUTY_BITS; j++) begin
      dv_r[j]  <= dv_r[j-1];
      ovf_r[j] <= ovf_r[j-1];
    end
  end

  // saturate at full scale, then at 16 bits
  always_comb begin
    full   = ovf_r[DUTY_BITS] ? MAXD : q_r[DUTY_BITS];
    dext   = DW'(full);
    duty_o = (dext > DW'(16'hFFFF)) ? 16'hFFFF : dext[15:0];
  end

endmodule

@@ rtl/core/two_link_leg_ik_servo_duty_top.sv @@
// Top level of the two-link leg IK servo block: config registers, side
// delay lines, angle stages and output register. Depends on tlik_pkg and all tlik_* modules.
//
// One command transaction (foot x/y, hip yaw, leg) is taken in every clock
// cycle: busy stays low, so start alone accepts a transaction. Each command
// gives exactly one result, on the out_ ports for one cycle with out_valid
// high, after 4 front-end stages, 26 square-root stages (default package
// constants), CORDIC_STEPS+1 CORDIC stages, 2 angle stages, DUTY_BITS+5
// duty stages and 1 output register. The receiver cannot stall: results
// leave in command order and must be taken when shown. Write configuration
// only while no command is in flight.
module two_link_leg_ik_servo_duty_top import tlik_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // command channel
  input  logic              start,
  output logic              busy,
  input  logic [7:0]        in_foot_x,
  input  logic signed [8:0] in_foot_y,
  input  logic [7:0]        in_hip_yaw_deg,
  input  logic [1:0]        in_leg_sel,
  // configuration write port
  input  logic              cfg_wr_en,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_wdata,
  // result channel
  output logic              out_valid,
  output logic [1:0]        out_leg_out,
  output logic              out_reachable,
  output logic [7:0]        out_femur_servo_deg,
  output logic [7:0]        out_tibia_servo_deg,
  output logic [15:0]       out_femur_duty,
  output logic [15:0]       out_tibia_duty,
  output logic [15:0]       out_coxa_duty
);

  localparam logic [2:0] CFG_UPPER = 3'd0;
  localparam logic [2:0] CFG_LOWER = 3'd1;
  localparam logic [2:0] CFG_PMIN  = 3'd2;
  localparam logic [2:0] CFG_PMAX  = 3'd3;
  localparam logic [2:0] CFG_FRAME = 3'd4;

  // ---------------- configuration registers ----------------
  logic [11:0] upper_len_r, lower_len_r;
  logic [14:0] pmin_r, pmax_r;
  logic [15:0] frame_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_len_r <= 12'd808;
      lower_len_r <= 12'd1520;
      pmin_r      <= 15'd500;
      pmax_r      <= 15'd2550;
      frame_r     <= 16'd20000;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_UPPER: upper_len_r <= cfg_wdata[11:0];
        CFG_LOWER: lower_len_r <= cfg_wdata[11:0];
        CFG_PMIN:  pmin_r      <= cfg_wdata[14:0];
        CFG_PMAX:  pmax_r      <= cfg_wdata[14:0];
        CFG_FRAME: frame_r     <= cfg_wdata;
        default:   ;  // drop writes to unused indexes
      endcase
    end
  end

  // The pipeline never stalls, so a command is always taken.
  assign busy = 1'b0;

  // ---------------- front end: squares and discriminants ----------------
  front_t            front_side;
  logic [DISC_W-1:0] disc1, disc2;

  tlik_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (start),
    .x_i     (in_foot_x),
    .y_i     (in_foot_y),
    .yaw_i   (in_hip_yaw_deg),
    .leg_i   (in_leg_sel),
    .l1_i    (upper_len_r),
    .l2_i    (lower_len_r),
    .side_o  (front_side),
    .disc1_o (disc1),
    .disc2_o (disc2)
  );

  // ---------------- square roots of both discriminants ----------------
  logic [ROOT_W-1:0] root1, root2;

  tlik_isqrt u_isqrt1 (.clk(clk), .v_i(disc1), .root_o(root1));
  tlik_isqrt u_isqrt2 (.clk(clk), .v_i(disc2), .root_o(root2));

  // Carry the side record alongside the square-root stages.
  front_t fd_r [ISQ_STEPS];
  front_t fd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ISQ_STEPS; k++) fd_r[k].vld <= 1'b0;
    end else begin
      fd_r[0] <= front_side;
      for (int k = 1; k < ISQ_STEPS; k++) fd_r[k] <= fd_r[k-1];
    end
  end

  assign fd = fd_r[ISQ_STEPS-1];

  // ---------------- three CORDIC angle units ----------------
  // u_cor0: atan(y/x) of the target; u_cor1: hip law-of-cosines angle;
  // u_cor2: knee angle.
  logic signed [Z_W-1:0] z_tgt, z_hip, z_knee;

  tlik_cordic u_cor0 (
    .clk (clk),
    .a_i ({{(CIN_W-8){1'b0}}, fd.x}),
    .b_i ({{(CIN_W-9){fd.y[8]}}, fd.y}),
    .z_o (z_tgt)
  );

  tlik_cordic u_cor1 (
    .clk (clk),
    .a_i ({{(CIN_W-N_W){fd.n1[N_W-1]}}, fd.n1}),
    .b_i ({{(CIN_W-ROOT_W){1'b0}}, root1}),
    .z_o (z_hip)
  );

  tlik_cordic u_cor2 (
    .clk (clk),
    .a_i ({{(CIN_W-N_W){fd.n2[N_W-1]}}, fd.n2}),
    .b_i ({{(CIN_W-ROOT_W){1'b0}}, root2}),
    .z_o (z_knee)
  );

  mid_t md_r [COR_LAT];
  mid_t md_nxt, md;

  always_comb begin
    md_nxt.vld    = fd.vld;
    md_nxt.leg    = fd.leg;
    md_nxt.yaw    = fd.yaw;
    md_nxt.ok     = fd.ok;
    md_nxt.x_zero = (fd.x == '0);
    md_nxt.y_pos  = !fd.y[8] && (fd.y != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < COR_LAT; k++) md_r[k].vld <= 1'b0;
    end else begin
      md_r[0] <= md_nxt;
      for (int k = 1; k < COR_LAT; k++) md_r[k] <= md_r[k-1];
    end
  end

  assign md = md_r[COR_LAT-1];

  // ---------------- angle stage E: theta1 before truncation ----------------
  mid_t                e_side_r;
  logic signed [Z_W:0] e_diff_r, e_diff_nxt;
  logic signed [Z_W-1:0] e_knee_r, tt;

  always_comb begin
    // x of zero: atan(y/x) is exactly +/-90 degrees
    if (md.x_zero) tt = md.y_pos ? Z_90 : Z_N90;
    else           tt = z_tgt;
    e_diff_nxt = {z_hip[Z_W-1], z_hip} - {tt[Z_W-1], tt};
  end

  always_ff @(posedge clk) begin
    e_diff_r <= e_diff_nxt;
    e_knee_r <= z_knee;
    if (!rst_n) e_side_r.vld <= 1'b0;
    else        e_side_r     <= md;
  end

  // ---------------- angle stage F: truncate, limit check, servo angles ------
  ang_t       a_r, a_nxt;
  logic [6:0] th1;
  logic [7:0] th2;

  always_comb begin
    // truncation toward zero: a small negative angle reads as zero and passes
    th1 = e_diff_r[Z_W] ? '0 : e_diff_r[22:16];
    th2 = e_knee_r[Z_W-1] ? '0 : e_knee_r[23:16];
    a_nxt.vld = e_side_r.vld;
    a_nxt.leg = e_side_r.leg;
    a_nxt.ok  = e_side_r.ok
                && (e_diff_r > -Q16_ONE) && (e_diff_r < 91 * Q16_ONE)
                && (e_knee_r > -Q16_ONE) && (e_knee_r < 181 * Q16_ONE);
    a_nxt.fem = {1'b0, th1} + 8'd90;
    a_nxt.tib = 8'd180 - th2;
    a_nxt.yaw = (e_side_r.yaw > 8'd180) ? 8'd180 : e_side_r.yaw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) a_r.vld <= 1'b0;
    else        a_r     <= a_nxt;
  end

  // ---------------- duty units ----------------
  logic [15:0] fem_duty, tib_duty, cox_duty;

  tlik_servo u_srv_fem (.clk(clk), .angle_i(a_r.fem), .pmin_i(pmin_r), .pmax_i(pmax_r),
                        .frame_i(frame_r), .duty_o(fem_duty));
  tlik_servo u_srv_tib (.clk(clk), .angle_i(a_r.tib), .pmin_i(pmin_r), .pmax_i(pmax_r),
                        .frame_i(frame_r), .duty_o(tib_duty));
  tlik_servo u_srv_cox (.clk(clk), .angle_i(a_r.yaw), .pmin_i(pmin_r), .pmax_i(pmax_r),
                        .frame_i(frame_r), .duty_o(cox_duty));

  ang_t sd_r [SERVO_LAT];
  ang_t sd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SERVO_LAT; k++) sd_r[k].vld <= 1'b0;
    end else begin
      sd_r[0] <= a_r;
      for (int k = 1; k < SERVO_LAT; k++) sd_r[k] <= sd_r[k-1];
    end
  end

  assign sd = sd_r[SERVO_LAT-1];

  // ---------------- output register ----------------
  // An unreachable target zeroes every angle and duty; the leg still echoes.
  logic        out_valid_r, out_ok_r;
  logic [1:0]  out_leg_r;
  logic [7:0]  out_fem_deg_r, out_tib_deg_r;
  logic [15:0] out_fem_duty_r, out_tib_duty_r, out_cox_duty_r;

  always_ff @(posedge clk) begin
    out_leg_r      <= sd.leg;
    out_ok_r       <= sd.ok;
    out_fem_deg_r  <= sd.ok ? sd.fem : '0;
    out_tib_deg_r  <= sd.ok ? sd.tib : '0;
    out_fem_duty_r <= sd.ok ? fem_duty : '0;
    out_tib_duty_r <= sd.ok ? tib_duty : '0;
    out_cox_duty_r <= sd.ok ? cox_duty : '0;
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= sd.vld;
  end

  assign out_valid           = out_valid_r;
  assign out_leg_out         = out_leg_r;
  assign out_reachable       = out_ok_r;
  assign out_femur_servo_deg = out_fem_deg_r;
  assign out_tibia_servo_deg = out_tib_deg_r;
  assign out_femur_duty      = out_fem_duty_r;
  assign out_tibia_duty      = out_tib_duty_r;
  assign out_coxa_duty       = out_cox_duty_r;

endmodule

@@ verif/tb_two_link_leg_ik_servo_duty_top.sv @@
// Self-checking testbench for two_link_leg_ik_servo_duty_top: drives foot-target
// commands and configuration writes, predicts each result in a local model.
// Depends on tlik_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_two_link_leg_ik_servo_duty_top;
  import tlik_pkg::*;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_UPPER_LEN = 3'd0,
    REG_LOWER_LEN = 3'd1,
    REG_PULSE_MIN = 3'd2,
    REG_PULSE_MAX = 3'd3,
    REG_FRAME     = 3'd4,
    REG_SPARE5    = 3'd5,
    REG_SPARE6    = 3'd6,
    REG_SPARE7    = 3'd7
  } cfg_reg_e;

  // One servo result as the block should report it
  typedef struct {
    logic [1:0]  leg;
    logic        reach;
    logic [7:0]  femur_deg;
    logic [7:0]  tibia_deg;
    logic [15:0] femur_duty;
    logic [15:0] tibia_duty;
    logic [15:0] coxa_duty;
  } servo_cmd_t;

  localparam int DRAIN_CYCLES = 90;   // longer than the full pipeline

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [7:0]        in_foot_x = '0;
  logic signed [8:0] in_foot_y = '0;
  logic [7:0]        in_hip_yaw_deg = '0;
  logic [1:0]        in_leg_sel = '0;
  logic              cfg_wr_en = 1'b0;
  logic [2:0]        cfg_index = '0;
  logic [15:0]       cfg_wdata = '0;
  logic              out_valid;
  logic [1:0]        out_leg_out;
  logic              out_reachable;
  logic [7:0]        out_femur_servo_deg;
  logic [7:0]        out_tibia_servo_deg;
  logic [15:0]       out_femur_duty;
  logic [15:0]       out_tibia_duty;
  logic [15:0]       out_coxa_duty;

  two_link_leg_ik_servo_duty_top dut (.*);

  always #10 clk = ~clk;

  // Shadow copy of the configuration registers
  longint upper_len = 808, lower_len = 1520, pulse_min = 500, pulse_max = 2550;
  longint frame_len = 20000;

  servo_cmd_t pending_servo_q[$];
  int  error_count = 0;
  bit  gaps_on = 1'b1;

  // atan(2^-i), Q16 degrees
  longint arctan_tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
    29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Vectoring CORDIC: angle of (a, b) in Q16 degrees
  function automatic longint vector_angle(longint a, longint b);
    longint vx = a * 65536, vy = b * 65536, z = 0, t, dx, dy;
    if (vx < 0) begin
      t = vx; vx = vy; vy = -t; z = 90 * 65536;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy >= 0) begin
        vx += dx; vy -= dy; z += arctan_tbl[i];
      end else begin
        vx -= dx; vy += dy; z -= arctan_tbl[i];
      end
    end
    return z;
  endfunction

  function automatic longint whole_deg(longint z);
    return (z < 0) ? -((-z) >>> 16) : (z >>> 16);
  endfunction

  function automatic logic [15:0] servo_duty(longint angle);
    longint d, p, q, pulse;
    longint unsigned maxd, f, pu, v;
    d = pulse_max - pulse_min;
    p = angle * d;
    q = p / 180;                      // truncates toward zero
    pulse = q + pulse_min;
    maxd = (64'd1 << DUTY_BITS) - 1;
    f = (frame_len != 0) ? frame_len : 1;
    pu = (pulse > 0) ? pulse : 0;
    v = (2 * pu * maxd + f) / (2 * f);
    if (v > maxd) v = maxd;
    if (v > 64'hFFFF) v = 64'hFFFF;
    return v[15:0];
  endfunction

  function automatic servo_cmd_t solve_leg(logic [7:0] fx, logic signed [8:0] fy,
                                           logic [7:0] yaw_in, logic [1:0] leg);
    servo_cmd_t r;
    longint x, y, yaw, l1sq, l2sq, s, n1, n2, disc1, disc2, tt, th1, th2;
    bit ok;
    x = fx; y = fy; yaw = yaw_in;
    l1sq = upper_len * upper_len;
    l2sq = lower_len * lower_len;
    s = 256 * (x * x + y * y);
    n1 = l1sq + s - l2sq;
    n2 = l1sq + l2sq - s;
    disc1 = 4 * l1sq * s - n1 * n1;
    disc2 = 4 * l1sq * l2sq - n2 * n2;
    ok = upper_len > 0 && lower_len > 0 && s > 0 && disc1 >= 0 && disc2 >= 0;
    th1 = 0; th2 = 0;
    if (ok) begin
      // Straight up or down: no CORDIC for the target direction
      if (x == 0) tt = (y > 0) ? 90 * 65536 : -90 * 65536;
      else        tt = vector_angle(x, y);
      th1 = whole_deg(vector_angle(n1, floor_sqrt(disc1)) - tt);
      th2 = whole_deg(vector_angle(n2, floor_sqrt(disc2)));
      ok = th1 >= 0 && th1 <= 90 && th2 >= 0 && th2 <= 180;
    end
    r = '{leg, 1'b0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0};
    if (ok) begin
      if (yaw > 180) yaw = 180;
      r.reach      = 1'b1;
      r.femur_deg  = 8'(th1 + 90);
      r.tibia_deg  = 8'(180 - th2);
      r.femur_duty = servo_duty(th1 + 90);
      r.tibia_duty = servo_duty(180 - th2);
      r.coxa_duty  = servo_duty(yaw);
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    error_count++;
  endtask

  // Result checker: every strobed result must match the oldest pending command
  always @(posedge clk) begin
    servo_cmd_t e;
    if (rst_n && out_valid) begin
      if (pending_servo_q.size() == 0) begin
        report_mismatch("results outstanding", 1, 0);
      end else begin
        e = pending_servo_q.pop_front();
        if (out_leg_out !== e.leg) report_mismatch("leg_out", out_leg_out, e.leg);
        if (out_reachable !== e.reach) report_mismatch("reachable", out_reachable, e.reach);
        if (out_femur_servo_deg !== e.femur_deg)
          report_mismatch("femur_servo_deg", out_femur_servo_deg, e.femur_deg);
        if (out_tibia_servo_deg !== e.tibia_deg)
          report_mismatch("tibia_servo_deg", out_tibia_servo_deg, e.tibia_deg);
        if (out_femur_duty !== e.femur_duty)
          report_mismatch("femur_duty", out_femur_duty, e.femur_duty);
        if (out_tibia_duty !== e.tibia_duty)
          report_mismatch("tibia_duty", out_tibia_duty, e.tibia_duty);
        if (out_coxa_duty !== e.coxa_duty)
          report_mismatch("coxa_duty", out_coxa_duty, e.coxa_duty);
      end
    end
  end

  // Hold start low for a random gap; mostly short, a few long.
  // Called at a falling edge, returns at a falling edge.
  task automatic idle_gap();
    int n;
    if (!gaps_on) return;
    n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 40);
    if (n == 0) return;
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Send one command transaction; starts and ends at a falling edge.
  // Start is left high so back-to-back commands never drop it.
  task automatic send_cmd(logic [7:0] fx, logic signed [8:0] fy, logic [7:0] yaw,
                          logic [1:0] leg);
    bit was_busy;
    start = 1'b1;
    in_foot_x = fx; in_foot_y = fy; in_hip_yaw_deg = yaw; in_leg_sel = leg;
    forever begin
      was_busy = busy;            // stable between edges
      @(posedge clk);
      if (!was_busy) break;
      @(negedge clk);
    end
    pending_servo_q.push_back(solve_leg(fx, fy, yaw, leg));
    @(negedge clk);
    idle_gap();
  endtask

  // Drop start, let all results come back, then let the pipe empty
  task automatic drain_all();
    start = 1'b0;
    while (pending_servo_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write one register; block must be idle
  task automatic write_reg(cfg_reg_e idx, logic [15:0] val);
    cfg_wr_en = 1'b1; cfg_index = idx; cfg_wdata = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      REG_UPPER_LEN: upper_len = val & 16'h0FFF;
      REG_LOWER_LEN: lower_len = val & 16'h0FFF;
      REG_PULSE_MIN: pulse_min = val & 16'h7FFF;
      REG_PULSE_MAX: pulse_max = val & 16'h7FFF;
      REG_FRAME:     frame_len = val;
      default: ;     // spare indexes are ignored by the block
    endcase
  endtask

  task automatic write_all(logic [15:0] l1, logic [15:0] l2, logic [15:0] pmin,
                           logic [15:0] pmax, logic [15:0] fr);
    drain_all();
    write_reg(REG_UPPER_LEN, l1);
    write_reg(REG_LOWER_LEN, l2);
    write_reg(REG_PULSE_MIN, pmin);
    write_reg(REG_PULSE_MAX, pmax);
    write_reg(REG_FRAME, fr);
  endtask

  // Mostly targets inside the leg's reach, some full-range noise
  task automatic send_random_cmd();
    int rmax;
    logic [7:0] fx;
    logic signed [8:0] fy;
    if ($urandom_range(0, 9) < 7) begin
      rmax = int'((upper_len + lower_len) / 16);
      if (rmax > 255) rmax = 255;
      if (rmax < 1) rmax = 1;
      fx = 8'($urandom_range(0, rmax));
      fy = 9'($urandom_range(0, 2 * rmax)) - 9'(rmax);
    end else begin
      fx = 8'($urandom);
      fy = 9'($urandom);
      if (fy == -9'sd256) fy = -9'sd255;
    end
    send_cmd(fx, fy, 8'($urandom), 2'($urandom));
  endtask

  // Field extremes and special cases at reset configuration
  task automatic test_directed();
    send_cmd(8'd0, 9'sd0, 8'd90, 2'd0);       // foot at the hip
    send_cmd(8'd0, 9'sd100, 8'd0, 2'd1);      // straight up, x zero
    send_cmd(8'd0, -9'sd100, 8'd180, 2'd2);   // straight down, x zero
    send_cmd(8'd100, 9'sd0, 8'd255, 2'd3);    // yaw saturates
    send_cmd(8'd60, -9'sd60, 8'd181, 2'd0);
    send_cmd(8'd120, 9'sd50, 8'd45, 2'd1);
    send_cmd(8'd90, -9'sd90, 8'd135, 2'd2);
    send_cmd(8'd255, 9'sd255, 8'd10, 2'd3);   // out of reach
    send_cmd(8'd255, -9'sd255, 8'd20, 2'd0);
    send_cmd(8'd10, 9'sd5, 8'd30, 2'd1);      // too close
    send_cmd(8'd145, 9'sd0, 8'd60, 2'd2);     // near full stretch
    send_cmd(8'd44, 9'sd0, 8'd70, 2'd3);      // near full fold
    send_cmd(8'd1, -9'sd80, 8'd100, 2'd0);
    send_cmd(8'd0, -9'sd255, 8'd128, 2'd1);
    send_cmd(8'd0, 9'sd255, 8'd127, 2'd2);
    send_cmd(8'd70, 9'sd70, 8'd1, 2'd3);
    send_cmd(8'd50, -9'sd120, 8'd179, 2'd0);
    send_cmd(8'd128, -9'sd1, 8'd64, 2'd1);
  endtask

  // Corner configurations, each followed by a short random batch
  task automatic test_config_corners();
    write_all(16'd0, 16'd1520, 16'd500, 16'd2550, 16'd20000);      // zero upper link
    repeat (20) send_random_cmd();
    write_all(16'd808, 16'd0, 16'd500, 16'd2550, 16'd20000);       // zero lower link
    repeat (20) send_random_cmd();
    write_all(16'd4095, 16'd4095, 16'd20000, 16'd0, 16'd1000);     // max reversed
    repeat (40) send_random_cmd();
    write_all(16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF, 16'd0);         // masking, frame 0
    repeat (40) send_random_cmd();
    write_all(16'd1, 16'd4095, 16'd0, 16'd20000, 16'd65535);
    repeat (40) send_random_cmd();
    write_all(16'd808, 16'd1520, 16'd500, 16'd2550, 16'd20000);
    write_reg(REG_SPARE5, 16'hFFFF);
    write_reg(REG_SPARE6, 16'h1234);
    write_reg(REG_SPARE7, 16'h0000);
    repeat (40) send_random_cmd();
  endtask

  // Bulk random commands across random configurations
  task automatic test_random_bulk();
    for (int phase = 0; phase < 10; phase++) begin
      write_all(16'($urandom_range(1, 4095)), 16'($urandom_range(1, 4095)),
                16'($urandom_range(0, 20000)), 16'($urandom_range(0, 20000)),
                16'($urandom_range(1000, 65535)));
      gaps_on = (phase % 3) != 2;   // some phases run back to back
      repeat (100) send_random_cmd();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_config_corners();
    test_random_bulk();
    drain_all();
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
